// ----- rtl/core/rsokf_pkg.sv -----
package rsokf_pkg;

  // Store capacity in records.
  localparam int MAX_RECORDS = 32;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // Fewest stored records that need a sort pass.
  localparam int SORT_MIN = 2;

  localparam int KEY_W  = 32;
  localparam int HEAD_W = 64;
  localparam int TAIL_W = 8;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HEAD_W-1:0]       name_head;
    logic [TAIL_W-1:0]       name_tail;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// ----- rtl/core/rsokf_in_if.sv -----
interface rsokf_in_if;
  import rsokf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;
  logic [HEAD_W-1:0]       name_head;
  logic [TAIL_W-1:0]       name_tail;
  logic                    last_record;

  modport source (output valid, key, name_head, name_tail, last_record, input ready);
  modport sink   (input valid, key, name_head, name_tail, last_record, output ready);

endinterface

// ----- rtl/core/rsokf_out_if.sv -----
interface rsokf_out_if;
  import rsokf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] out_key;
  logic [HEAD_W-1:0]       out_name_head;
  logic [TAIL_W-1:0]       out_name_tail;
  logic                    last_out;
  logic                    empty_res;
  logic                    overflowed;

  modport source (output valid, out_key, out_name_head, out_name_tail, last_out, empty_res,
                  overflowed, input ready);
  modport sink   (input valid, out_key, out_name_head, out_name_tail, last_out, empty_res,
                  overflowed, output ready);

endinterface

// ----- rtl/core/rsokf_ram.sv -----
module rsokf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual-port storage with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/record_sort_odd_key_filter.sv -----
// While loading, each record request is taken as it is offered. After the request marked
// last, with n records stored, the sort runs for n >= 2 (no sort pass for n = 1), then the
// emit pass checks each stored record in turn and a closing step ends the set; output stalls hold it up.
// One set at a time; input is not ready from a set's last record to its final result.
// Reset (rst_n, synchronous, active low) clears the record count, overflow flag and handshake
// state and sets drop_odd to 1; the record store is not cleared.
module record_sort_odd_key_filter (
  input  logic              clk,
  input  logic              rst_n,
  rsokf_in_if.sink          in_rec,
  rsokf_out_if.source       out_rec,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import rsokf_pkg::*;

  // The sequencer runs the exchange sort on one shared compare unit over a record RAM
  // with a single write port and a single registered read port. For each position i the
  // record at i is held in cur_r; each later record j is read, compared against cur_r,
  // and on a swap the old cur_r is written back at j while the smaller record becomes
  // cur_r. When j runs out, cur_r is written to i. This gives exactly the order of the
  // in-place exchange sort, at one compare per cycle.
  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_CUR,
    S_CMP,
    S_WR,
    S_ERD,
    S_ECHK,
    S_EFIN
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HEAD_W-1:0]       name_head;
    logic [TAIL_W-1:0]       name_tail;
    logic                    last;
    logic                    empty;
    logic                    ovf;
  } out_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             drop_odd_r;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] e_r, e_nxt;
  rec_t             cur_r, cur_nxt;
  rec_t             pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  out_t             out_r, out_nxt;
  logic             out_v_r, out_v_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  rec_t             ram_wdata;
  rec_t             ram_rdata;

  logic             in_acc;
  logic             slot_free;
  logic             keep;
  rec_t             in_data;

  rsokf_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_rec.ready = (state_r == S_LOAD);
  assign in_acc       = in_rec.valid && in_rec.ready;

  assign in_data.key       = in_rec.key;
  assign in_data.name_head = in_rec.name_head;
  assign in_data.name_tail = in_rec.name_tail;

  // The output register frees up in the same cycle that its request is taken.
  assign slot_free = !out_v_r || out_rec.ready;

  // A record read during the emit pass is kept unless odd keys are being dropped and its
  // key is odd. Two's complement makes bit 0 the odd test for negative keys too.
  assign keep = !(drop_odd_r && ram_rdata.key[0]);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    e_nxt      = e_r;
    cur_nxt    = cur_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;

    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = in_data;
    ram_raddr = i_r;

    if (out_v_r && out_rec.ready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_rec.last_record) begin
            i_nxt = '0;
            e_nxt = '0;
            if (count_nxt >= CNT_W'(SORT_MIN)) begin
              state_nxt = S_START;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end

      S_START: begin
        ram_raddr = i_r;
        state_nxt = S_CUR;
      end

      S_CUR: begin
        cur_nxt   = ram_rdata;
        ram_raddr = i_r + IDX_W'(1);
        j_nxt     = i_r + IDX_W'(1);
        state_nxt = S_CMP;
      end

      S_CMP: begin
        ram_raddr = j_r + IDX_W'(1);
        if (cur_r.key > ram_rdata.key) begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = cur_r;
          cur_nxt   = ram_rdata;
        end
        if (CNT_W'(j_r) + CNT_W'(1) < count_r) begin
          j_nxt = j_r + IDX_W'(1);
        end else begin
          state_nxt = S_WR;
        end
      end

      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = cur_r;
        ram_raddr = i_r + IDX_W'(1);
        i_nxt     = i_r + IDX_W'(1);
        if (CNT_W'(i_r) + CNT_W'(SORT_MIN) < count_r) begin
          state_nxt = S_CUR;
        end else begin
          e_nxt     = '0;
          state_nxt = S_ERD;
        end
      end

      S_ERD: begin
        ram_raddr = e_r;
        state_nxt = S_ECHK;
      end

      S_ECHK: begin
        // The address stays put so the read data holds while the output is stalled.
        ram_raddr = e_r;
        // A kept record is parked until the next kept one shows up, so that the final
        // result can be marked last.
        if (!keep || !pend_v_r || slot_free) begin
          if (keep) begin
            if (pend_v_r) begin
              out_v_nxt         = 1'b1;
              out_nxt.key       = pend_r.key;
              out_nxt.name_head = pend_r.name_head;
              out_nxt.name_tail = pend_r.name_tail;
              out_nxt.last      = 1'b0;
              out_nxt.empty     = 1'b0;
              out_nxt.ovf       = ovf_r;
            end
            pend_nxt   = ram_rdata;
            pend_v_nxt = 1'b1;
          end
          if (CNT_W'(e_r) + CNT_W'(1) < count_r) begin
            e_nxt     = e_r + IDX_W'(1);
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_EFIN;
          end
        end
      end

      S_EFIN: begin
        if (slot_free) begin
          out_v_nxt = 1'b1;
          out_nxt.last  = 1'b1;
          out_nxt.ovf   = ovf_r;
          if (pend_v_r) begin
            out_nxt.key       = pend_r.key;
            out_nxt.name_head = pend_r.name_head;
            out_nxt.name_tail = pend_r.name_tail;
            out_nxt.empty     = 1'b0;
          end else begin
            // Every record was filtered out: one empty marker closes the set.
            out_nxt.key       = '0;
            out_nxt.name_head = '0;
            out_nxt.name_tail = '0;
            out_nxt.empty     = 1'b1;
          end
          pend_v_nxt = 1'b0;
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      drop_odd_r <= 1'b1;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_we) begin
        drop_odd_r <= cfg_wdata;
      end
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    e_r    <= e_nxt;
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_rec.valid         = out_v_r;
  assign out_rec.out_key       = out_r.key;
  assign out_rec.out_name_head = out_r.name_head;
  assign out_rec.out_name_tail = out_r.name_tail;
  assign out_rec.last_out      = out_r.last;
  assign out_rec.empty_res     = out_r.empty;
  assign out_rec.overflowed    = out_r.ovf;

  // Nothing may stay parked once the block is back to loading.
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !pend_v_r)
    else $error("parked record left over while loading");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  // The inner sort index always lies after the outer one and inside the stored set.
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((CNT_W'(j_r) < count_r) && (j_r > i_r)))
    else $error("sort index out of range");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rec.valid && out_rec.empty_res) |-> (out_rec.last_out && (out_rec.out_key == '0)))
    else $error("empty marker malformed");

  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EFIN) && slot_free) |=> ((state_r == S_LOAD) && (count_r == '0)
      && out_rec.valid && out_rec.last_out))
    else $error("set did not close cleanly");

endmodule
